[design/ihts_pkg.sv]
// Shared types, constants and helpers for the image header type/size sniffer.
`default_nettype none

package ihts_pkg;

    localparam int unsigned DEFAULT_MAX_IMAGE_BYTES = 1048576;

    localparam int unsigned LEN_W = 21;
    localparam int unsigned DIM_W = 16;
    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HEIGHT   = 2'd2;

    localparam logic [LEN_W-1:0] IMAGE_LENGTH_RESET = 21'h100000;
    localparam logic [DIM_W-1:0] MAX_DIM_RESET      = 16'hffff;

    // shorter images are reported as no known kind
    localparam int unsigned MIN_KIND_BYTES = 16;
    // a marker's FF must sit before length minus this
    localparam int unsigned JPEG_TAIL = 10;

    localparam logic [7:0] MARK_PREFIX = 8'hff;
    localparam logic [7:0] JPEG_SOI    = 8'hd8;

    localparam logic [7:0] GIF_SIG [6] = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61};
    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4e, 8'h47,
                                           8'h0d, 8'h0a, 8'h1a, 8'h0a};

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_JPEG = 2'd1,
        KIND_GIF  = 2'd2,
        KIND_PNG  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_LEN    = 2'd1,
        PH_SOF    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] max_width;
        logic [DIM_W-1:0] max_height;
    } limits_t;

    typedef struct packed {
        kind_t            kind;
        logic             found;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             fits;
    } result_t;

    function automatic logic is_sof(input logic [7:0] b);
        return b inside {[8'hc0:8'hc3], [8'hc9:8'hcb]};
    endfunction

endpackage

`default_nettype wire

[design/image_header_type_size_sniffer.sv]
// Top level: config registers, input stage, parser and result register.
//
// Usage: stream the bytes of one image on the input channel (valid/ready),
// one byte per beat, with end_of_image high on the final byte. One result
// beat (kind, found flag, width, height, limit check) leaves on the output
// channel for each image, nothing for the other bytes.
// Throughput: one byte per cycle, sustained but for the stall below; the input
// stage and the parser state update together, in the same cycle.
// Result path: the final byte is registered in the input stage, then parsed
// straight into the result register, whose contents form the result beat;
// while that register is busy the byte waits in the input stage.
// Stalls: bytes without the end mark keep flowing while a result waits;
// a final byte is held in the input stage until the result register is free.
// Configuration: image_length, max_width and max_height are written through
// write_enable/reg_index/write_data between images.
// Reset: all parser state cleared, image_length = 1 MiB, limits unlimited;
// no flush pass is needed, the block accepts bytes straight away.
`default_nettype none

module image_header_type_size_sniffer #(
    parameter int unsigned MAX_IMAGE_BYTES = ihts_pkg::DEFAULT_MAX_IMAGE_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              write_enable,
    input  wire logic [ihts_pkg::CFG_INDEX_W-1:0]  reg_index,
    input  wire logic [ihts_pkg::CFG_DATA_W-1:0]   write_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              end_of_image,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             image_kind,
    output logic                                   size_found,
    output logic [ihts_pkg::DIM_W-1:0]             pixel_width,
    output logic [ihts_pkg::DIM_W-1:0]             pixel_height,
    output logic                                   fits_limits
);

    localparam int unsigned OW = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int unsigned CW = (OW > ihts_pkg::LEN_W) ? OW : ihts_pkg::LEN_W;

    logic [ihts_pkg::LEN_W-1:0] image_length_reg;
    ihts_pkg::limits_t          limits_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_last_reg;
    logic                       s1_fire;

    logic                       out_valid_reg, out_valid_next;
    ihts_pkg::result_t          out_reg;
    ihts_pkg::result_t          core_result;

    logic [CW-1:0]              len_ext;
    logic [CW-1:0]              len_cap;
    logic [CW-1:0]              len_min;
    logic [OW-1:0]              eff_len;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg      <= ihts_pkg::IMAGE_LENGTH_RESET;
            limits_reg.max_width  <= ihts_pkg::MAX_DIM_RESET;
            limits_reg.max_height <= ihts_pkg::MAX_DIM_RESET;
        end
        else if (write_enable)
        begin
            case (reg_index)
                ihts_pkg::CFG_IMAGE_LENGTH: image_length_reg <= write_data;
                ihts_pkg::CFG_MAX_WIDTH:
                    limits_reg.max_width <= write_data[ihts_pkg::DIM_W-1:0];
                ihts_pkg::CFG_MAX_HEIGHT:
                    limits_reg.max_height <= write_data[ihts_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        len_ext = CW'(image_length_reg);
        len_cap = CW'(MAX_IMAGE_BYTES);
        len_min = (len_ext < len_cap) ? len_ext : len_cap;
        eff_len = len_min[OW-1:0];
    end

    // a final byte only moves on when the result register can take it
    always_comb
    begin
        s1_fire        = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || s1_fire;
        s1_valid_next  = in_valid || (s1_valid_reg && !s1_fire);
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && s1_last_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_ready ? in_valid : s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= end_of_image;
        end
        if (s1_fire && s1_last_reg)
            out_reg <= core_result;
    end

    ihts_core #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_fire),
        .byte_in (s1_byte_reg),
        .last    (s1_last_reg),
        .eff_len (eff_len),
        .limits  (limits_reg),
        .result  (core_result)
    );

    assign out_valid    = out_valid_reg;
    assign image_kind   = out_reg.kind;
    assign size_found   = out_reg.found;
    assign pixel_width  = out_reg.width;
    assign pixel_height = out_reg.height;
    assign fits_limits  = out_reg.fits;

endmodule

`default_nettype wire

[design/ihts_core.sv]
// Per-byte header parser: signature match, GIF/PNG field capture and JPEG marker scan.
`default_nettype none

module ihts_core #(
    parameter int unsigned MAX_IMAGE_BYTES = ihts_pkg::DEFAULT_MAX_IMAGE_BYTES,
    localparam int unsigned OW = $clog2(MAX_IMAGE_BYTES + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        byte_in,
    input  wire logic              last,
    input  wire logic [OW-1:0]     eff_len,
    input  wire ihts_pkg::limits_t limits,
    output ihts_pkg::result_t      result
);

    localparam int unsigned NW = ((OW > ihts_pkg::DIM_W) ? OW : ihts_pkg::DIM_W) + 1;

    logic [OW-1:0]         off_reg, off_next;
    logic [7:0]            sig_reg [8];
    logic [7:0]            sig_next [8];
    logic [7:0]            sig_view [8];
    ihts_pkg::kind_t       kind_reg, kind_next;
    ihts_pkg::phase_t      phase_reg, phase_next;
    logic [NW-1:0]         nco_reg, nco_next;
    logic [OW-1:0]         marker_reg, marker_next;
    logic [15:0]           width_reg, width_next;
    logic [15:0]           height_reg, height_next;
    logic                  found_reg, found_next;
    logic [7:0]            prev_reg, prev_next;
    logic [7:0]            seg_hi_reg, seg_hi_next;

    logic                  acc;
    logic [OW-1:0]         delta;
    logic                  tail_hit;
    logic                  jpeg_match, gif_match, png_match;
    logic                  do_pair;
    logic [7:0]            pair_prev;
    logic [15:0]           seg;
    ihts_pkg::kind_t       kind_res;
    logic                  found_res;

    always_comb
    begin
        off_next    = off_reg;
        kind_next   = kind_reg;
        phase_next  = phase_reg;
        nco_next    = nco_reg;
        marker_next = marker_reg;
        width_next  = width_reg;
        height_next = height_reg;
        found_next  = found_reg;
        prev_next   = prev_reg;
        seg_hi_next = seg_hi_reg;
        do_pair     = 1'b0;
        pair_prev   = prev_reg;

        acc      = off_reg < eff_len;
        delta    = off_reg - marker_reg;
        tail_hit = ({1'b0, off_reg} + (OW + 1)'(ihts_pkg::JPEG_TAIL - 1)) >= {1'b0, eff_len};
        seg      = {seg_hi_reg, byte_in};

        for (int k = 0; k < 8; k++)
        begin
            sig_view[k] = (off_reg == OW'(k)) ? byte_in : sig_reg[k];
            sig_next[k] = acc ? sig_view[k] : sig_reg[k];
        end

        jpeg_match = (sig_view[0] == ihts_pkg::MARK_PREFIX) && (sig_view[1] == ihts_pkg::JPEG_SOI);
        gif_match  = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            gif_match = gif_match && (sig_view[k] == ihts_pkg::GIF_SIG[k]);
        end
        png_match = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            png_match = png_match && (sig_view[k] == ihts_pkg::PNG_SIG[k]);
        end

        if (acc)
        begin
            if (off_reg == OW'(1) && jpeg_match)
                kind_next = ihts_pkg::KIND_JPEG;
            if (off_reg == OW'(5) && gif_match)
                kind_next = ihts_pkg::KIND_GIF;
            if (off_reg == OW'(7) && png_match)
                kind_next = ihts_pkg::KIND_PNG;

            case (kind_next)
                ihts_pkg::KIND_JPEG:
                begin
                    case (phase_reg)
                        ihts_pkg::PH_SEARCH:
                        begin
                            if (NW'(off_reg) > nco_reg)
                                do_pair = 1'b1;
                        end
                        ihts_pkg::PH_LEN:
                        begin
                            if (delta == OW'(1))
                            begin
                                seg_hi_next = byte_in;
                            end
                            else if (delta == OW'(2))
                            begin
                                phase_next = ihts_pkg::PH_SEARCH;
                                if (seg >= 16'd2)
                                begin
                                    nco_next = NW'(marker_reg) + NW'(seg);
                                end
                                else
                                begin
                                    // degenerate length: rescan from the length bytes
                                    do_pair   = 1'b1;
                                    pair_prev = seg_hi_reg;
                                end
                            end
                        end
                        ihts_pkg::PH_SOF:
                        begin
                            if (delta == OW'(4))
                                height_next[15:8] = byte_in;
                            else if (delta == OW'(5))
                                height_next[7:0] = byte_in;
                            else if (delta == OW'(6))
                                width_next[15:8] = byte_in;
                            else if (delta == OW'(7))
                            begin
                                width_next[7:0] = byte_in;
                                found_next      = 1'b1;
                                phase_next      = ihts_pkg::PH_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_pair)
                    begin
                        if (tail_hit)
                        begin
                            phase_next = ihts_pkg::PH_DONE;
                        end
                        else if (pair_prev == ihts_pkg::MARK_PREFIX &&
                                 byte_in != ihts_pkg::MARK_PREFIX)
                        begin
                            marker_next = off_reg;
                            phase_next  = ihts_pkg::is_sof(byte_in) ? ihts_pkg::PH_SOF
                                                                    : ihts_pkg::PH_LEN;
                        end
                        else
                        begin
                            nco_next = NW'(off_reg);
                        end
                    end
                end
                ihts_pkg::KIND_GIF:
                begin
                    // little-endian pairs
                    if (off_reg == OW'(6))
                        width_next[7:0] = byte_in;
                    else if (off_reg == OW'(7))
                        width_next[15:8] = byte_in;
                    else if (off_reg == OW'(8))
                        height_next[7:0] = byte_in;
                    else if (off_reg == OW'(9))
                    begin
                        height_next[15:8] = byte_in;
                        found_next        = 1'b1;
                    end
                end
                ihts_pkg::KIND_PNG:
                begin
                    // low halves of the big-endian IHDR words
                    if (off_reg == OW'(18))
                        width_next[15:8] = byte_in;
                    else if (off_reg == OW'(19))
                        width_next[7:0] = byte_in;
                    else if (off_reg == OW'(22))
                        height_next[15:8] = byte_in;
                    else if (off_reg == OW'(23))
                    begin
                        height_next[7:0] = byte_in;
                        found_next       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            prev_next = byte_in;
            off_next  = off_reg + OW'(1);
        end

        kind_res  = (off_next >= OW'(ihts_pkg::MIN_KIND_BYTES)) ? kind_next : ihts_pkg::KIND_NONE;
        found_res = (kind_res != ihts_pkg::KIND_NONE) && found_next;

        result.kind   = kind_res;
        result.found  = found_res;
        result.width  = found_res ? width_next : 16'd0;
        result.height = found_res ? height_next : 16'd0;
        result.fits   = found_res && (width_next <= limits.max_width) &&
                        (height_next <= limits.max_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            kind_reg   <= ihts_pkg::KIND_NONE;
            phase_reg  <= ihts_pkg::PH_SEARCH;
            nco_reg    <= NW'(2);
            marker_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            found_reg  <= 1'b0;
            prev_reg   <= '0;
            seg_hi_reg <= '0;
            for (int k = 0; k < 8; k++)
            begin
                sig_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            if (last)
            begin
                // image done: back to the idle state for the next one
                off_reg    <= '0;
                kind_reg   <= ihts_pkg::KIND_NONE;
                phase_reg  <= ihts_pkg::PH_SEARCH;
                nco_reg    <= NW'(2);
                marker_reg <= '0;
                width_reg  <= '0;
                height_reg <= '0;
                found_reg  <= 1'b0;
                prev_reg   <= '0;
                seg_hi_reg <= '0;
                for (int k = 0; k < 8; k++)
                begin
                    sig_reg[k] <= '0;
                end
            end
            else
            begin
                off_reg    <= off_next;
                kind_reg   <= kind_next;
                phase_reg  <= phase_next;
                nco_reg    <= nco_next;
                marker_reg <= marker_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                found_reg  <= found_next;
                prev_reg   <= prev_next;
                seg_hi_reg <= seg_hi_next;
                for (int k = 0; k < 8; k++)
                begin
                    sig_reg[k] <= sig_next[k];
                end
            end
        end
    end

endmodule

`default_nettype wire
